// File: rtl/core/sid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the signed integer divider core.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(DATA_W - 1);
    localparam logic [DATA_W-1:0] MAX_POS   = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] numerator;
        logic signed [DATA_W-1:0] denominator;
    } t_in_data;

    typedef struct packed {
        logic signed [DATA_W-1:0] quotient;
        logic                     div_by_zero;
        logic                     overflow;
    } t_out_data;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_step;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/core/signed_integer_divider_core.sv
// Sequence: load on the accepting edge, 32 restoring steps of the shared
//   subtractor, 1 sign fixup into the output register.
// One beat at a time: the next beat is taken only after the sign fixup.
//   A new beat is taken while the previous result waits in the output register.
// Reset: synchronous, active low; clears the sequencer and the result valid.
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_divider_core
// Signed 32-bit divider: floor quotient for a positive divisor, truncated
// quotient for a negative one, with divide-by-zero and overflow flags.
// ----------------------------------------------------------------------------
module signed_integer_divider_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sid_pkg::t_in_data  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sid_pkg::t_out_data      o_out_data
);

    sid_pkg::t_dp_cmd cmd;
    sid_pkg::t_dp_sts sts;

    sid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sid_dpath u_dpath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

// File: rtl/core/sid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer for the divider: load, one quotient bit per cycle, sign fixup,
// and the valid flag of the output register.
// ----------------------------------------------------------------------------
module sid_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output sid_pkg::t_dp_cmd      o_cmd,
    input  wire sid_pkg::t_dp_sts i_sts
);

    sid_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sid_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sid_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sid_pkg::ST_DIV;
                end
            end
            sid_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = sid_pkg::ST_FIX;
                end
            end
            sid_pkg::ST_FIX: begin
                // wait here while the previous result still sits unclaimed
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fix = 1'b1;
                    n_state   = sid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sid_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.fix) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/core/sid_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sid_dpath
// Magnitude restoring divider, one quotient bit per step, with sign fixup
// and the output register.
// ----------------------------------------------------------------------------
module sid_dpath (
    input  wire logic              i_clk,
    input  wire sid_pkg::t_in_data i_in_data,
    input  wire sid_pkg::t_dp_cmd  i_cmd,
    output sid_pkg::t_dp_sts       o_sts,
    output sid_pkg::t_out_data     o_out_data
);

    localparam int W = sid_pkg::DATA_W;

    logic [W-1:0]               r_quo, r_rem, r_mb;
    logic                       r_a_neg, r_b_neg, r_dz;
    logic [sid_pkg::CNT_W-1:0]  r_cnt;
    sid_pkg::t_out_data         r_out, n_out;

    logic [W-1:0] a_raw, b_raw, ma, mb;
    logic [W:0]   shifted, diff;
    logic         rem_nz;

    assign a_raw = i_in_data.numerator;
    assign b_raw = i_in_data.denominator;
    assign ma    = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
    assign mb    = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;

    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= ma;
            r_rem   <= '0;
            r_mb    <= mb;
            r_a_neg <= a_raw[W-1];
            r_b_neg <= b_raw[W-1];
            r_dz    <= (mb == '0);
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            r_rem <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~diff[W]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_sts.last_step = (r_cnt == sid_pkg::LAST_STEP);

    assign rem_nz = |r_rem;

    always_comb begin
        n_out             = '0;
        if (r_dz) begin
            n_out.div_by_zero = 1'b1;
        end else if (!r_b_neg) begin
            // floor: -(q+1) is ~q when a remainder is left
            if (r_a_neg) begin
                n_out.quotient = rem_nz ? ~r_quo : (~r_quo + 1'b1);
            end else begin
                n_out.quotient = r_quo;
            end
        end else if (r_a_neg) begin
            // only most negative over minus one lands on the sign bit
            if (r_quo[W-1]) begin
                n_out.quotient = sid_pkg::MAX_POS;
                n_out.overflow = 1'b1;
            end else begin
                n_out.quotient = r_quo;
            end
        end else begin
            n_out.quotient = ~r_quo + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

// File: rtl/core/sid_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sid_chk
// Port-level checks for the divider core, bound to the top level.
// ----------------------------------------------------------------------------
module sid_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire sid_pkg::t_in_data  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire sid_pkg::t_out_data o_out_data
);

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one item at a time: no new beat right after an accepted one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_by_zero |->
            o_out_data.quotient == '0 && !o_out_data.overflow)
        else $error("bad divide-by-zero result");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            o_out_data.quotient == sid_pkg::MAX_POS)
        else $error("overflow without saturation");

endmodule

bind signed_integer_divider_core sid_chk u_sid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// File: bench/signed_integer_divider_core_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_divider_core_test
// Self-checking bench for the signed divider core. A short table of corner
// operands runs first, then random operand pairs. Each accepted beat is
// predicted (from the table or in the bench: floor for a positive divisor,
// truncation for a negative one, zero-divisor and overflow flags), checked in
// order against the output beats, with random stalls on both sides of the core.
// ----------------------------------------------------------------------------
module signed_integer_divider_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;

    localparam logic signed [sid_pkg::DATA_W-1:0] MOST_NEG =
        {1'b1, {(sid_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [sid_pkg::DATA_W-1:0] MOST_POS = sid_pkg::MAX_POS;

    typedef struct {
        logic signed [sid_pkg::DATA_W-1:0] num;
        logic signed [sid_pkg::DATA_W-1:0] den;
        bit                                typed;
        logic signed [sid_pkg::DATA_W-1:0] quo;
        bit                                dz;
        bit                                ov;
    } t_corner;

    localparam int N_CORNERS = 24;

    t_corner corner_rows [N_CORNERS] = '{
        '{0,        0,        1'b1, 0,        1'b1, 1'b0},
        '{5,        0,        1'b1, 0,        1'b1, 1'b0},
        '{MOST_NEG, 0,        1'b1, 0,        1'b1, 1'b0},
        '{-1,       0,        1'b1, 0,        1'b1, 1'b0},
        '{MOST_POS, 0,        1'b1, 0,        1'b1, 1'b0},
        '{MOST_NEG, -1,       1'b1, MOST_POS, 1'b0, 1'b1},
        '{MOST_NEG, 1,        1'b1, MOST_NEG, 1'b0, 1'b0},
        '{MOST_POS, 1,        1'b1, MOST_POS, 1'b0, 1'b0},
        '{0,        7,        1'b1, 0,        1'b0, 1'b0},
        '{0,        -7,       1'b1, 0,        1'b0, 1'b0},
        '{0,        MOST_NEG, 1'b1, 0,        1'b0, 1'b0},
        '{MOST_POS, -1,       1'b0, 0,        1'b0, 1'b0},
        '{7,        2,        1'b0, 0,        1'b0, 1'b0},
        '{-7,       2,        1'b0, 0,        1'b0, 1'b0},
        '{7,        -2,       1'b0, 0,        1'b0, 1'b0},
        '{-7,       -2,       1'b0, 0,        1'b0, 1'b0},
        '{-6,       2,        1'b0, 0,        1'b0, 1'b0},
        '{-1,       MOST_POS, 1'b0, 0,        1'b0, 1'b0},
        '{MOST_NEG, MOST_NEG, 1'b0, 0,        1'b0, 1'b0},
        '{MOST_POS, MOST_NEG, 1'b0, 0,        1'b0, 1'b0},
        '{MOST_NEG, MOST_POS, 1'b0, 0,        1'b0, 1'b0},
        '{MOST_NEG, -2,       1'b0, 0,        1'b0, 1'b0},
        '{-1,       -1,       1'b0, 0,        1'b0, 1'b0},
        '{1,        MOST_NEG, 1'b0, 0,        1'b0, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sid_pkg::t_in_data  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    sid_pkg::t_out_data o_out_data;

    sid_pkg::t_out_data pending_quotients [$];
    sid_pkg::t_out_data oldest_quotient;
    int                 mismatch_cnt  = 0;
    int                 results_done  = 0;
    int                 quiet_cycles  = 0;
    bit                 hold_done     = 1'b0;

    signed_integer_divider_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // magnitude divide, then floor (positive divisor) or truncate (negative)
    function automatic sid_pkg::t_out_data signed_quotient(input sid_pkg::t_in_data op);
        logic [sid_pkg::DATA_W-1:0] num, den, ma, mb, q, r, mag;
        logic                       a_neg, b_neg;
        sid_pkg::t_out_data         res;
        num   = op.numerator;
        den   = op.denominator;
        a_neg = num[sid_pkg::DATA_W-1];
        b_neg = den[sid_pkg::DATA_W-1];
        ma    = a_neg ? ~num + 1'b1 : num;
        mb    = b_neg ? ~den + 1'b1 : den;
        res   = '0;
        if (mb == '0) begin
            res.div_by_zero = 1'b1;
        end else begin
            q = ma / mb;
            r = ma % mb;
            if (!b_neg) begin
                // round down only matters below zero
                mag          = (a_neg && r != '0) ? q + 1'b1 : q;
                res.quotient = a_neg ? ~mag + 1'b1 : mag;
            end else if (a_neg) begin
                if (q > sid_pkg::MAX_POS) begin
                    res.quotient = sid_pkg::MAX_POS;
                    res.overflow = 1'b1;
                end else begin
                    res.quotient = q;
                end
            end else begin
                res.quotient = ~q + 1'b1;
            end
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [sid_pkg::DATA_W-1:0] rand_operand();
        logic signed [sid_pkg::DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: v = v >>> $urandom_range(0, 31);
            2: begin
                v = $urandom_range(0, 24);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = -1;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            default: v = v >>> $urandom_range(8, 30);
        endcase
        return v;
    endfunction

    // hold the beat until it is taken, then record its expected quotient
    task automatic offer(input sid_pkg::t_in_data op, input sid_pkg::t_out_data want);
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_quotients.push_back(want);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        sid_pkg::t_in_data  op;
        sid_pkg::t_out_data want;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_rows[k]) begin
            op.numerator   = corner_rows[k].num;
            op.denominator = corner_rows[k].den;
            if (corner_rows[k].typed) begin
                want.quotient    = corner_rows[k].quo;
                want.div_by_zero = corner_rows[k].dz;
                want.overflow    = corner_rows[k].ov;
            end else begin
                want = signed_quotient(op);
            end
            offer(op, want);
            idle_sender(pick_gap());
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // sender pause: let the core drain completely
            if (n == RANDOM_ITEMS / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_quotients.size() != 0)
                    @(posedge i_clk);
            end
            op.numerator   = rand_operand();
            op.denominator = rand_operand();
            offer(op, signed_quotient(op));
            // back-to-back stretch with no sender gaps
            idle_sender((n >= 100 && n < 220) ? 0 : pick_gap());
        end

        i_in_valid <= 1'b0;
        while (pending_quotients.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_quotients.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            if (!hold_done && results_done >= 30) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= 1'b1;
                repeat (($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 20))
                    @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_done <= results_done + 1;
            if (pending_quotients.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: result beat with nothing pending: quotient %0d dz %0b ov %0b",
                             $realtime, o_out_data.quotient, o_out_data.div_by_zero,
                             o_out_data.overflow);
            end else begin
                oldest_quotient = pending_quotients.pop_front();
                if (o_out_data.quotient    !== oldest_quotient.quotient    ||
                    o_out_data.div_by_zero !== oldest_quotient.div_by_zero ||
                    o_out_data.overflow    !== oldest_quotient.overflow) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: quotient %0d dz %0b ov %0b, expected %0d dz %0b ov %0b",
                                 $realtime, o_out_data.quotient, o_out_data.div_by_zero,
                                 o_out_data.overflow, oldest_quotient.quotient,
                                 oldest_quotient.div_by_zero, oldest_quotient.overflow);
                end
            end
        end
    end

    // watchdog: no beat on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
